// ===== hdl/prlt_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// prlt_pkg: shared types and constants of the ping round-trip/loss tracker
// Item structs, opcode and status codes, register indexes.
// -----------------------------------------------------------------------------
package prlt_pkg;

	localparam logic [1:0] OP_SENT   = 2'd0;
	localparam logic [1:0] OP_RESP   = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_RECORDED  = 3'd0;
	localparam logic [2:0] ST_IN_TIME   = 3'd1;
	localparam logic [2:0] ST_LATE      = 3'd2;
	localparam logic [2:0] ST_UNMATCHED = 3'd3;
	localparam logic [2:0] ST_NONE      = 3'd4;
	localparam logic [2:0] ST_REPORT    = 3'd5;

	localparam logic [0:0] REG_TIMEOUT = 1'd0;
	localparam logic [0:0] REG_ALARM   = 1'd1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;
	localparam logic [6:0]  ALARM_RESET   = 7'd25;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] sequence_req;
		logic [31:0] timestamp_us;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] round_trip_us;
		logic [31:0] average_rtt_us;
		logic [3:0]  in_use_count;
		logic [3:0]  lost_count;
		logic [6:0]  loss_percent;
		logic        loss_high;
	} out_item_t;

endpackage
`default_nettype wire

// ===== hdl/ping_rtt_loss_tracker_top.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ping_rtt_loss_tracker_top: ping round-trip and loss tracker
// Queue-style event input, queue-style result output, register write port.
// -----------------------------------------------------------------------------
// Events enter a two-deep queue and one sequencer handles them one at a time;
// each event gives exactly one result into a two-deep result queue. A sent
// event is recorded in the table straight away; a response compares one table
// entry a cycle; a check runs the table scan, one RTT store read a cycle, a
// one-bit-a-cycle divider for the average and a subtract loop for the loss
// percent, which is at most 100. Registers are to be written only while no
// event is in flight; the block itself does not enforce this, it is up to
// the user.
module ping_rtt_loss_tracker_top #(
	parameter int REQUEST_ENTRIES = 8,
	parameter int RTT_DEPTH       = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  prlt_pkg::in_item_t  in_item,
	output logic                empty,
	input  wire                 pop,
	output prlt_pkg::out_item_t out_item,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [0:0]          cfg_index,
	input  wire  [31:0]         cfg_data
);
	logic [31:0] timeout_q;
	logic [6:0]  alarm_q;
	logic        c_avail, c_take, r_valid, r_take, r_space;
	prlt_pkg::in_item_t  c_item;
	prlt_pkg::out_item_t r_item;

	assign cfg_ready = 1'b1;
	assign r_take    = r_valid && r_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= prlt_pkg::TIMEOUT_RESET;
			alarm_q   <= prlt_pkg::ALARM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				prlt_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				prlt_pkg::REG_ALARM:   alarm_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	prlt_cmd_fifo u_cmd (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(in_item),
		.avail(c_avail), .take(c_take), .dout(c_item)
	);

	prlt_engine #(.REQUEST_ENTRIES(REQUEST_ENTRIES), .RTT_DEPTH(RTT_DEPTH)) u_eng (
		.clk(clk), .arst_n(arst_n), .cmd_avail(c_avail), .cmd_take(c_take),
		.cmd(c_item), .timeout_us(timeout_q), .alarm_pct(alarm_q),
		.res_valid(r_valid), .res_take(r_take), .res(r_item)
	);

	prlt_res_fifo u_res (
		.clk(clk), .arst_n(arst_n), .wr(r_take), .space(r_space), .din(r_item),
		.empty(empty), .pop(pop), .dout(out_item)
	);
endmodule
`default_nettype wire

// ===== hdl/prlt_cmd_fifo.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// prlt_cmd_fifo: front queue
// Two-entry queue that accepts events and hands them to the engine.
// -----------------------------------------------------------------------------
module prlt_cmd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  prlt_pkg::in_item_t  din,
	output logic                avail,
	input  wire                 take,
	output prlt_pkg::in_item_t  dout
);
	prlt_pkg::in_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_take;

	assign full    = cnt_q[1];
	assign avail   = cnt_q != 2'd0;
	assign dout    = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_take) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 && !push |=> cnt_q == 2'd0)
		else $error("queue count moved without push");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full && !take |=> full)
		else $error("full dropped without take");
endmodule
`default_nettype wire

// ===== hdl/prlt_engine.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// prlt_engine: event sequencer
// Walks the request table one entry a cycle, sums the RTT store one entry a
// cycle, divides bit-serially and counts the loss percent by subtraction, then presents one result.
// -----------------------------------------------------------------------------
module prlt_engine #(
	parameter int REQUEST_ENTRIES = 8,
	parameter int RTT_DEPTH       = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_avail,
	output logic                cmd_take,
	input  prlt_pkg::in_item_t  cmd,
	input  wire  [31:0]         timeout_us,
	input  wire  [6:0]          alarm_pct,
	output logic                res_valid,
	input  wire                 res_take,
	output prlt_pkg::out_item_t res
);
	localparam int RW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
	localparam int TW = (RTT_DEPTH > 1) ? $clog2(RTT_DEPTH) : 1;
	localparam int FW = $clog2(RTT_DEPTH + 1);
	localparam int CW = $clog2(REQUEST_ENTRIES + 1);
	localparam int SW = 32 + TW + 1;
	localparam int PW = CW + 7;

	typedef enum logic [3:0] {
		S_IDLE, S_MATCH, S_PUSH, S_SCAN, S_SUM, S_DIVA, S_DIVP, S_OUT
	} state_t;

	state_t state_q;
	logic [31:0] seq_q [REQUEST_ENTRIES];
	logic [31:0] sent_q [REQUEST_ENTRIES];
	logic [REQUEST_ENTRIES-1:0] ans_q;
	logic [RW-1:0] wptr_q, idx_q;
	logic [31:0] rtt_mem [RTT_DEPTH];
	logic [TW-1:0] rptr_q;
	logic [FW-1:0] ridx_q;
	logic [FW-1:0] filled_q;
	logic [CW-1:0] used_q, lost_q;
	logic [31:0] now_q, seqin_q, rtt_q;
	logic [SW-1:0] sum_q, rem_q, quo_q;
	logic [PW-1:0] prem_q;
	logic [6:0] pquo_q;
	logic [5:0] bit_q;
	logic [31:0] rd_q;
	logic rd_v_q;
	prlt_pkg::out_item_t res_q;

	logic [31:0] age;
	logic [SW:0] rem_sh;
	logic [CW+13:0] lost100, alarm_x;
	prlt_pkg::out_item_t res_init;

	assign cmd_take  = state_q == S_IDLE && cmd_avail && !res_valid;
	assign res       = res_q;
	assign age       = now_q - sent_q[idx_q];
	assign rem_sh    = {rem_q, sum_q[SW-1]};
	assign lost100   = (CW+14)'(lost_q) * (CW+14)'(100);
	assign alarm_x   = (CW+14)'(alarm_pct) * (CW+14)'(used_q);

	always_comb begin
		res_init = '0;
		case (cmd.opcode)
			prlt_pkg::OP_SENT: res_init.status = prlt_pkg::ST_RECORDED;
			prlt_pkg::OP_RESP, prlt_pkg::OP_CHECK: ;
			default: res_init.status = prlt_pkg::ST_UNMATCHED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH) begin
			rtt_mem[rptr_q] <= rtt_q;
		end
		rd_q <= rtt_mem[ridx_q[TW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ans_q     <= '0;
			wptr_q    <= '0;
			rptr_q    <= '0;
			filled_q  <= '0;
			res_valid <= 1'b0;
			idx_q <= '0; ridx_q <= '0; rd_v_q <= 1'b0;
			for (int i = 0; i < REQUEST_ENTRIES; i++) begin
				seq_q[i]  <= '0;
				sent_q[i] <= '0;
			end
		end else begin
			if (res_valid && res_take) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						now_q   <= cmd.timestamp_us;
						seqin_q <= cmd.sequence_req;
						idx_q   <= '0;
						res_q   <= res_init;
						used_q  <= '0;
						lost_q  <= '0;
						case (cmd.opcode)
							prlt_pkg::OP_SENT: begin
								seq_q[wptr_q]  <= cmd.sequence_req;
								sent_q[wptr_q] <= cmd.timestamp_us;
								ans_q[wptr_q]  <= 1'b0;
								wptr_q <= (wptr_q == RW'(REQUEST_ENTRIES - 1)) ? '0 : wptr_q + 1'b1;
								state_q <= S_OUT;
							end
							prlt_pkg::OP_RESP: state_q <= S_MATCH;
							prlt_pkg::OP_CHECK: state_q <= S_SCAN;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_MATCH: begin
					// first unanswered entry with matching sequence wins
					if (seq_q[idx_q] == seqin_q && !ans_q[idx_q]) begin
						ans_q[idx_q] <= 1'b1;
						rtt_q <= age;
						res_q.round_trip_us <= age;
						if (age <= timeout_us) begin
							res_q.status <= prlt_pkg::ST_IN_TIME;
							state_q <= S_PUSH;
						end else begin
							res_q.status <= prlt_pkg::ST_LATE;
							state_q <= S_OUT;
						end
					end else if (idx_q == RW'(REQUEST_ENTRIES - 1)) begin
						res_q.status <= prlt_pkg::ST_UNMATCHED;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_PUSH: begin
					rptr_q <= (rptr_q == TW'(RTT_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
					if (filled_q != FW'(RTT_DEPTH)) begin
						filled_q <= filled_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (seq_q[idx_q] != '0) begin
						used_q <= used_q + 1'b1;
						if (!ans_q[idx_q] && age > timeout_us) begin
							lost_q <= lost_q + 1'b1;
						end
					end
					if (idx_q == RW'(REQUEST_ENTRIES - 1)) begin
						ridx_q <= '0;
						rd_v_q <= 1'b0;
						sum_q  <= '0;
						state_q <= S_SUM;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SUM: begin
					// issue one store read a cycle; its data lands in rd_q in the next cycle
					if (used_q == '0) begin
						res_q.status <= prlt_pkg::ST_NONE;
						state_q <= S_OUT;
					end else begin
						if (rd_v_q) begin
							sum_q <= sum_q + SW'(rd_q);
						end
						if (ridx_q < filled_q) begin
							ridx_q <= ridx_q + 1'b1;
							rd_v_q <= 1'b1;
						end else begin
							rd_v_q <= 1'b0;
							if (!rd_v_q) begin
								state_q <= S_DIVA;
								rem_q <= '0;
								quo_q <= '0;
								bit_q <= 6'(SW);
							end
						end
					end
				end
				S_DIVA: begin
					if (rd_v_q) begin
						sum_q <= sum_q + SW'(rd_q);
						rd_v_q <= 1'b0;
					end else if (filled_q == '0) begin
						res_q.average_rtt_us <= '0;
						bit_q <= 6'd7;
						prem_q <= PW'(lost_q);
						pquo_q <= '0;
						state_q <= S_DIVP;
					end else if (bit_q == '0) begin
						res_q.average_rtt_us <= quo_q[31:0];
						bit_q <= 6'd7;
						prem_q <= PW'(lost_q);
						pquo_q <= '0;
						state_q <= S_DIVP;
					end else begin
						sum_q <= {sum_q[SW-2:0], 1'b0};
						if (rem_sh >= (SW+1)'(filled_q)) begin
							rem_q <= SW'(rem_sh - (SW+1)'(filled_q));
							quo_q <= {quo_q[SW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[SW-1:0];
							quo_q <= {quo_q[SW-2:0], 1'b0};
						end
						bit_q <= bit_q - 1'b1;
					end
				end
				S_DIVP: begin
					// load lost*100, then subtract used until it drops below;
					// the count of subtractions is the percent
					if (bit_q == 6'd7) begin
						prem_q <= PW'(lost100);
						bit_q  <= 6'd6;
						pquo_q <= '0;
					end else if (prem_q >= PW'(used_q)) begin
						prem_q <= prem_q - PW'(used_q);
						pquo_q <= pquo_q + 1'b1;
					end else begin
						res_q.status       <= prlt_pkg::ST_REPORT;
						res_q.in_use_count <= 4'(used_q);
						res_q.lost_count   <= 4'(lost_q);
						res_q.loss_percent <= pquo_q;
						res_q.loss_high    <= lost100 >= alarm_x;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					res_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_filled_max: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FW'(RTT_DEPTH))
		else $error("rtt fill count beyond depth");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> !res_valid)
		else $error("took event with result pending");
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> res_valid)
		else $error("result not raised");
endmodule
`default_nettype wire

// ===== hdl/prlt_res_fifo.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// prlt_res_fifo: result queue
// Two-entry queue between the engine and the result port.
// -----------------------------------------------------------------------------
module prlt_res_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr,
	output logic                 space,
	input  prlt_pkg::out_item_t  din,
	output logic                 empty,
	input  wire                  pop,
	output prlt_pkg::out_item_t  dout
);
	prlt_pkg::out_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_pop;

	assign space  = !cnt_q[1];
	assign empty  = cnt_q == 2'd0;
	assign dout   = mem_q[rp_q];
	assign do_wr  = wr && space;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result queue overflow");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_wr |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("pop did not drain");
	a_wr_fills: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("write did not fill");
endmodule
`default_nettype wire
